// ===== rtl/core/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants for the board feature perceptron evaluator.
// ----------------------------------------------------------------------------
package bfm_pkg;

    localparam int FEATURES_DEF     = 28;
    localparam int HIDDEN_UNITS_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int COUNT_W   = 7;
    localparam int COUNT_MAX = 127;
    localparam int AMOUNT_W  = 5;
    localparam int HAND_KINDS = 7;

    localparam logic [15:0] VALID_KINDS = 16'hDFFE;
    localparam logic [3:0] KIND_OF_PIECE [16] = '{
        4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
        4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd0, 4'd12, 4'd13
    };

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_BOARD = 2'd1,
        MODE_HAND  = 2'd2,
        MODE_EVAL  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_B2,
        TAG_B1,
        TAG_W1,
        TAG_W2,
        TAG_DONE
    } tag_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic add;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/bfm_cell.sv =====
// ----------------------------------------------------------------------------
// bfm_cell
// One feature count: saturating add, clear, and shift from its neighbour.
// ----------------------------------------------------------------------------
module bfm_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bfm_pkg::cell_ctrl_t             ctrl,
    input  logic [bfm_pkg::AMOUNT_W-1:0]    amount,
    input  logic [bfm_pkg::COUNT_W-1:0]     shift_in,
    output logic [bfm_pkg::COUNT_W-1:0]     count
);

    logic [bfm_pkg::COUNT_W-1:0] count_reg;
    logic [bfm_pkg::COUNT_W-1:0] count_next;
    logic [bfm_pkg::COUNT_W:0]   sum;

    always_comb begin
        sum        = {1'b0, count_reg} + (bfm_pkg::COUNT_W + 1)'(amount);
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.shift) begin
            count_next = shift_in;
        end else if (ctrl.add) begin
            if (sum > (bfm_pkg::COUNT_W + 1)'(bfm_pkg::COUNT_MAX)) begin
                count_next = bfm_pkg::COUNT_W'(bfm_pkg::COUNT_MAX);
            end else begin
                count_next = sum[bfm_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ===== rtl/core/board_feature_mlp_evaluator.sv =====
// Load, board and hand items are taken at once; the block is ready again next cycle.
// An evaluate item reads every weight in turn through the single read port of the
// weight memory, one weight per cycle.
// One item is in work at a time; a finished score waits in the output register.
// Synchronous active-low reset clears the counts and control; weights are kept
// undefined until loaded.
// ----------------------------------------------------------------------------
// board_feature_mlp_evaluator
// Two-layer ReLU perceptron over a rotating chain of feature count cells.
// ----------------------------------------------------------------------------
module board_feature_mlp_evaluator #(
    parameter int FEATURES     = bfm_pkg::FEATURES_DEF,
    parameter int HIDDEN_UNITS = bfm_pkg::HIDDEN_UNITS_DEF,
    parameter int WEIGHT_BITS  = bfm_pkg::WEIGHT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [9:0]         s_weight_index,
    input  logic signed [15:0] s_weight_value,
    input  logic signed [4:0]  s_piece_code,
    input  logic               s_hand_side,
    input  logic [4:0]         s_hand_pawns,
    input  logic [2:0]         s_hand_lances,
    input  logic [2:0]         s_hand_knights,
    input  logic [2:0]         s_hand_silvers,
    input  logic [2:0]         s_hand_golds,
    input  logic [1:0]         s_hand_bishops,
    input  logic [1:0]         s_hand_rooks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_score
);

    localparam int SIDE     = FEATURES / 2;
    localparam int W1_COUNT = HIDDEN_UNITS * FEATURES;
    localparam int B1_BASE  = W1_COUNT;
    localparam int W2_BASE  = B1_BASE + HIDDEN_UNITS;
    localparam int B2_SLOT  = W2_BASE + HIDDEN_UNITS;
    localparam int STORE    = B2_SLOT + 1;
    localparam int ADDR_W   = $clog2(STORE);
    localparam int FI_W     = $clog2(FEATURES);
    localparam int HI_W     = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int P1_W     = WEIGHT_BITS + bfm_pkg::COUNT_W + 1;
    localparam int HS_W     = P1_W + $clog2(FEATURES + 1) + 1;
    localparam int P2_W     = WEIGHT_BITS + HS_W;
    localparam int CW       = ((P2_W > 64) ? P2_W : 64) + 1;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;

    bfm_pkg::state_t state_reg, state_next;
    bfm_pkg::tag_t   cur_tag_reg, cur_tag_next;
    logic [FI_W-1:0]   i_reg, i_next;
    logic [HI_W-1:0]   h_reg, h_next;
    logic [ADDR_W-1:0] w1_addr_reg, w1_addr_next;
    logic [ADDR_W-1:0] rd_addr;

    logic accept, issue_en, fin_go, start_eval;

    // weight memory
    logic signed [WEIGHT_BITS-1:0] weight_mem [STORE];
    logic signed [WEIGHT_BITS-1:0] rd_data_reg;
    bfm_pkg::tag_t                 tag1_reg;

    // pipeline
    bfm_pkg::tag_t                 tag2_reg, tag3_reg, tag4_reg;
    logic signed [WEIGHT_BITS-1:0] q2_reg;
    logic signed [P1_W-1:0]        prod2_reg;
    logic signed [HS_W-1:0]        hsum_reg;
    logic signed [WEIGHT_BITS-1:0] w2_reg;
    logic signed [HS_W-1:0]        relu_reg;
    logic signed [63:0]            prod4_reg;
    logic signed [63:0]            acc_reg;
    logic signed [P1_W-1:0]        prod1;
    logic signed [P2_W-1:0]        prod3;
    logic signed [CW-1:0]          prod3_ext;
    logic signed [63:0]            prod3_sat;
    logic signed [64:0]            acc_sum;
    logic signed [63:0]            acc_add;
    logic signed [63:0]            acc_rnd;
    logic signed [47:0]            score_wide;
    logic signed [31:0]            score;

    logic                          m_valid_reg;
    logic signed [31:0]            m_score_reg;

    // count chain
    bfm_pkg::cell_ctrl_t               cell_ctrl [FEATURES];
    logic [bfm_pkg::AMOUNT_W-1:0]      amount    [FEATURES];
    logic [bfm_pkg::COUNT_W-1:0]       counts    [FEATURES];
    logic                              chain_shift;
    logic                              piece_hit;
    logic [4:0]                        mag;
    logic [3:0]                        kind;
    logic [bfm_pkg::AMOUNT_W-1:0]      hand_amt  [bfm_pkg::HAND_KINDS];

    assign accept     = s_valid && s_ready;
    assign start_eval = accept && (s_mode == bfm_pkg::MODE_EVAL);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfm_pkg::ST_IDLE: begin
                if (start_eval) state_next = bfm_pkg::ST_ISSUE;
            end
            bfm_pkg::ST_ISSUE: begin
                if (cur_tag_reg == bfm_pkg::TAG_DONE) state_next = bfm_pkg::ST_DRAIN;
            end
            bfm_pkg::ST_DRAIN: begin
                if (tag4_reg == bfm_pkg::TAG_DONE) state_next = bfm_pkg::ST_FIN;
            end
            bfm_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) state_next = bfm_pkg::ST_IDLE;
            end
            default: state_next = bfm_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_ready  = 1'b0;
        issue_en = 1'b0;
        fin_go   = 1'b0;
        case (state_reg)
            bfm_pkg::ST_IDLE:  s_ready  = 1'b1;
            bfm_pkg::ST_ISSUE: issue_en = 1'b1;
            bfm_pkg::ST_FIN:   fin_go   = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // issue sequence: B2, then per unit B1, W1 x FEATURES, W2, then DONE
    always_comb begin
        cur_tag_next = cur_tag_reg;
        i_next       = i_reg;
        h_next       = h_reg;
        w1_addr_next = w1_addr_reg;
        rd_addr      = ADDR_W'(B2_SLOT);
        if (start_eval) begin
            cur_tag_next = bfm_pkg::TAG_B2;
            i_next       = '0;
            h_next       = '0;
            w1_addr_next = '0;
        end else if (issue_en) begin
            case (cur_tag_reg)
                bfm_pkg::TAG_B2: begin
                    cur_tag_next = bfm_pkg::TAG_B1;
                end
                bfm_pkg::TAG_B1: begin
                    rd_addr      = ADDR_W'(B1_BASE) + ADDR_W'(h_reg);
                    cur_tag_next = bfm_pkg::TAG_W1;
                    i_next       = '0;
                end
                bfm_pkg::TAG_W1: begin
                    rd_addr      = w1_addr_reg;
                    w1_addr_next = w1_addr_reg + 1'b1;
                    if (i_reg == FI_W'(FEATURES - 1)) begin
                        cur_tag_next = bfm_pkg::TAG_W2;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
                bfm_pkg::TAG_W2: begin
                    rd_addr = ADDR_W'(W2_BASE) + ADDR_W'(h_reg);
                    if (h_reg == HI_W'(HIDDEN_UNITS - 1)) begin
                        cur_tag_next = bfm_pkg::TAG_DONE;
                    end else begin
                        h_next       = h_reg + 1'b1;
                        cur_tag_next = bfm_pkg::TAG_B1;
                    end
                end
                bfm_pkg::TAG_DONE: cur_tag_next = bfm_pkg::TAG_NONE;
                default: cur_tag_next = bfm_pkg::TAG_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfm_pkg::ST_IDLE;
            cur_tag_reg <= bfm_pkg::TAG_NONE;
            i_reg       <= '0;
            h_reg       <= '0;
            w1_addr_reg <= '0;
            tag1_reg    <= bfm_pkg::TAG_NONE;
            tag2_reg    <= bfm_pkg::TAG_NONE;
            tag3_reg    <= bfm_pkg::TAG_NONE;
            tag4_reg    <= bfm_pkg::TAG_NONE;
        end else begin
            state_reg   <= state_next;
            cur_tag_reg <= cur_tag_next;
            i_reg       <= i_next;
            h_reg       <= h_next;
            w1_addr_reg <= w1_addr_next;
            tag1_reg    <= issue_en ? cur_tag_reg : bfm_pkg::TAG_NONE;
            tag2_reg    <= tag1_reg;
            tag3_reg    <= tag2_reg;
            tag4_reg    <= tag3_reg;
        end
    end

    // weight memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (accept && s_mode == bfm_pkg::MODE_LOAD && 32'(s_weight_index) < STORE) begin
            weight_mem[s_weight_index[ADDR_W-1:0]] <= WEIGHT_BITS'(s_weight_value);
        end
        rd_data_reg <= weight_mem[rd_addr];
    end

    // datapath
    assign chain_shift = (tag1_reg == bfm_pkg::TAG_W1);
    assign prod1 = P1_W'(rd_data_reg * $signed({1'b0, counts[0]}));
    assign prod3 = P2_W'(w2_reg * relu_reg);

    always_comb begin
        prod3_ext = CW'(prod3);
        if (prod3_ext > CW'(SAT_MAX)) begin
            prod3_sat = SAT_MAX;
        end else if (prod3_ext < CW'(SAT_MIN)) begin
            prod3_sat = SAT_MIN;
        end else begin
            prod3_sat = 64'(prod3_ext);
        end
        acc_sum = 65'(acc_reg) + 65'(prod4_reg);
        if (acc_sum > 65'(SAT_MAX)) begin
            acc_add = SAT_MAX;
        end else if (acc_sum < 65'(SAT_MIN)) begin
            acc_add = SAT_MIN;
        end else begin
            acc_add = 64'(acc_sum);
        end
        acc_rnd    = acc_reg[63] ? acc_reg + 64'sd65535 : acc_reg;
        score_wide = acc_rnd[63:16];
        if (score_wide > 48'sh0000_7FFF_FFFF) begin
            score = 32'sh7FFF_FFFF;
        end else if (score_wide < -48'sh0000_8000_0000) begin
            score = -32'sh8000_0000;
        end else begin
            score = score_wide[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        q2_reg    <= rd_data_reg;
        prod2_reg <= prod1;
        if (tag2_reg == bfm_pkg::TAG_B1) begin
            hsum_reg <= HS_W'(q2_reg);
        end else if (tag2_reg == bfm_pkg::TAG_W1) begin
            hsum_reg <= hsum_reg + HS_W'(prod2_reg);
        end
        if (tag2_reg == bfm_pkg::TAG_W2) begin
            w2_reg   <= q2_reg;
            relu_reg <= hsum_reg[HS_W-1] ? '0 : hsum_reg;
        end
        prod4_reg <= prod3_sat;
        if (tag2_reg == bfm_pkg::TAG_B2) begin
            acc_reg <= 64'(q2_reg) <<< 8;
        end else if (tag4_reg == bfm_pkg::TAG_W2) begin
            acc_reg <= acc_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (fin_go) begin
            m_score_reg <= score;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_score = m_score_reg;

    // count updates
    always_comb begin
        mag       = s_piece_code[4] ? 5'(-s_piece_code) : 5'(s_piece_code);
        kind      = bfm_pkg::KIND_OF_PIECE[mag[3:0]];
        piece_hit = !mag[4] && bfm_pkg::VALID_KINDS[mag[3:0]] && (32'(kind) < SIDE);
        hand_amt[0] = s_hand_pawns;
        hand_amt[1] = bfm_pkg::AMOUNT_W'(s_hand_lances);
        hand_amt[2] = bfm_pkg::AMOUNT_W'(s_hand_knights);
        hand_amt[3] = bfm_pkg::AMOUNT_W'(s_hand_silvers);
        hand_amt[4] = bfm_pkg::AMOUNT_W'(s_hand_golds);
        hand_amt[5] = bfm_pkg::AMOUNT_W'(s_hand_bishops);
        hand_amt[6] = bfm_pkg::AMOUNT_W'(s_hand_rooks);
        for (int j = 0; j < FEATURES; j++) begin
            amount[j] = '0;
            if (s_mode == bfm_pkg::MODE_BOARD && piece_hit) begin
                if (j == (s_piece_code[4] ? SIDE + 32'(kind) : 32'(kind))) begin
                    amount[j] = bfm_pkg::AMOUNT_W'(1);
                end
            end else if (s_mode == bfm_pkg::MODE_HAND) begin
                for (int k = 0; k < bfm_pkg::HAND_KINDS; k++) begin
                    if (k < SIDE && j == (s_hand_side ? SIDE + k : k)) begin
                        amount[j] = hand_amt[k];
                    end
                end
            end
            cell_ctrl[j].shift = chain_shift;
            cell_ctrl[j].clear = fin_go;
            cell_ctrl[j].add   = accept;
        end
    end

    for (genvar g = 0; g < FEATURES; g++) begin : g_cell
        bfm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl[g]),
            .amount   (amount[g]),
            .shift_in (counts[(g + 1) % FEATURES]),
            .count    (counts[g])
        );
    end

endmodule

// ===== rtl/core/bfm_checker.sv =====
// ----------------------------------------------------------------------------
// bfm_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bfm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_mode,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_score
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_score))
        else $error("result item dropped or changed while stalled");

    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == bfm_pkg::MODE_EVAL |=> !s_ready)
        else $error("ready after evaluate item");

    a_short_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode != bfm_pkg::MODE_EVAL |=> s_ready)
        else $error("not ready after single-cycle item");

endmodule

bind board_feature_mlp_evaluator bfm_checker u_bfm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_mode  (s_mode),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_score (m_score)
);

// ===== sim/tb_board_feature_mlp_evaluator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_board_feature_mlp_evaluator
// Loads a full weight set, then feeds board squares, hand counts and
// evaluations. A scoreboard built on an in-bench perceptron model checks
// every score. Both sides idle at random, and the result side stalls for
// a long stretch once so that the evaluator backs up.
// ----------------------------------------------------------------------------
module tb_board_feature_mlp_evaluator;

    localparam int NF      = bfm_pkg::FEATURES_DEF;
    localparam int NH      = bfm_pkg::HIDDEN_UNITS_DEF;
    localparam int B1_BASE = NF * NH;
    localparam int W2_BASE = B1_BASE + NH;
    localparam int B2_SLOT = W2_BASE + NH;
    localparam int N_WEIGHTS = B2_SLOT + 1;
    localparam int SIDE_OFS = NF / 2;

    typedef struct {
        bfm_pkg::mode_t    mode;
        logic [9:0]        widx;
        logic signed [15:0] wval;
        logic signed [4:0] piece;
        logic              side;
        logic [4:0]        pawns;
        logic [2:0]        lances, knights, silvers, golds;
        logic [1:0]        bishops, rooks;
    } bfm_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = '0;
    logic [9:0] s_weight_index = '0;
    logic signed [15:0] s_weight_value = '0;
    logic signed [4:0] s_piece_code = '0;
    logic s_hand_side = 1'b0;
    logic [4:0] s_hand_pawns = '0;
    logic [2:0] s_hand_lances = '0, s_hand_knights = '0, s_hand_silvers = '0;
    logic [2:0] s_hand_golds = '0;
    logic [1:0] s_hand_bishops = '0, s_hand_rooks = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_score;

    bfm_item_t pending_items[$];
    int        expected_scores[$];
    int        model_counts[NF];
    int        model_weights[N_WEIGHTS];
    int        cycle_no = 0;
    int        mismatches = 0;
    int        scores_checked = 0;
    int        items_accepted = 0;

    board_feature_mlp_evaluator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int score_position();
        longint acc, sum, sc;
        acc = longint'(model_weights[B2_SLOT]) * 256;
        for (int h = 0; h < NH; h++) begin
            sum = model_weights[B1_BASE + h];
            for (int i = 0; i < NF; i++)
                sum += longint'(model_weights[h * NF + i]) * model_counts[i];
            if (sum < 0) sum = 0;
            acc += longint'(model_weights[W2_BASE + h]) * sum;
        end
        sc = acc / 65536;
        if (sc > 64'sd2147483647) sc = 64'sd2147483647;
        if (sc < -64'sd2147483648) sc = -64'sd2147483648;
        return int'(sc);
    endfunction

    function automatic void bump_count(int idx, int amount);
        model_counts[idx] = (model_counts[idx] + amount > bfm_pkg::COUNT_MAX) ?
                            bfm_pkg::COUNT_MAX : model_counts[idx] + amount;
    endfunction

    function automatic void apply_item(bfm_item_t it);
        int mag, base;
        case (it.mode)
            bfm_pkg::MODE_LOAD: begin
                if (it.widx < N_WEIGHTS) model_weights[it.widx] = it.wval;
            end
            bfm_pkg::MODE_BOARD: begin
                mag = (it.piece < 0) ? -int'(it.piece) : int'(it.piece);
                if (mag > 0 && mag < 16 && bfm_pkg::VALID_KINDS[mag])
                    bump_count((it.piece > 0 ? 0 : SIDE_OFS) + bfm_pkg::KIND_OF_PIECE[mag], 1);
            end
            bfm_pkg::MODE_HAND: begin
                base = it.side ? SIDE_OFS : 0;
                bump_count(base + 0, it.pawns);
                bump_count(base + 1, it.lances);
                bump_count(base + 2, it.knights);
                bump_count(base + 3, it.silvers);
                bump_count(base + 4, it.golds);
                bump_count(base + 5, it.bishops);
                bump_count(base + 6, it.rooks);
            end
            default: begin
                expected_scores.push_back(score_position());
                foreach (model_counts[i]) model_counts[i] = 0;
            end
        endcase
    endfunction

    function automatic bfm_item_t noise_item(bfm_pkg::mode_t m);
        bfm_item_t it;
        it.mode = m;
        it.widx = $urandom; it.wval = $urandom; it.piece = $urandom;
        it.side = $urandom; it.pawns = $urandom; it.lances = $urandom;
        it.knights = $urandom; it.silvers = $urandom; it.golds = $urandom;
        it.bishops = $urandom; it.rooks = $urandom;
        return it;
    endfunction

    task automatic queue_load(int idx, int val);
        bfm_item_t it;
        it = noise_item(bfm_pkg::MODE_LOAD);
        it.widx = idx; it.wval = val;
        pending_items.push_back(it);
    endtask

    task automatic queue_board(int code);
        bfm_item_t it;
        it = noise_item(bfm_pkg::MODE_BOARD);
        it.piece = code;
        pending_items.push_back(it);
    endtask

    task automatic queue_hand(bit side, int p, int l, int k, int s, int g, int b, int r);
        bfm_item_t it;
        it = noise_item(bfm_pkg::MODE_HAND);
        it.side = side; it.pawns = p; it.lances = l; it.knights = k;
        it.silvers = s; it.golds = g; it.bishops = b; it.rooks = r;
        pending_items.push_back(it);
    endtask

    // driver, with the model updated on every accepted item
    always @(posedge aclk) begin
        bfm_item_t it;
        cycle_no <= cycle_no + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                it.mode = bfm_pkg::mode_t'(s_mode); it.widx = s_weight_index;
                it.wval = s_weight_value; it.piece = s_piece_code;
                it.side = s_hand_side; it.pawns = s_hand_pawns;
                it.lances = s_hand_lances; it.knights = s_hand_knights;
                it.silvers = s_hand_silvers; it.golds = s_hand_golds;
                it.bishops = s_hand_bishops; it.rooks = s_hand_rooks;
                apply_item(it);
                items_accepted <= items_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 &&
                    ((cycle_no > 3000 && cycle_no < 9000) || $urandom_range(99) >= 29)) begin
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= it.mode; s_weight_index <= it.widx;
                    s_weight_value <= it.wval; s_piece_code <= it.piece;
                    s_hand_side <= it.side; s_hand_pawns <= it.pawns;
                    s_hand_lances <= it.lances; s_hand_knights <= it.knights;
                    s_hand_silvers <= it.silvers; s_hand_golds <= it.golds;
                    s_hand_bishops <= it.bishops; s_hand_rooks <= it.rooks;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side: random idling plus one long hold-off
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!hold_done && scores_checked == 5 && m_valid) begin
            hold_left <= 6000;
            hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= (hold_left == 1);
        end else begin
            m_ready <= (cycle_no > 3000 && cycle_no < 9000) || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge aclk) begin
        int exp_score;
        if (aresetn && m_valid && m_ready) begin
            if (expected_scores.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected score %0d", m_score);
                mismatches <= mismatches + 1;
            end else begin
                exp_score = expected_scores.pop_front();
                if (exp_score != m_score) begin
                    if (mismatches < 10)
                        $display("score mismatch: expected %0d got %0d", exp_score, m_score);
                    mismatches <= mismatches + 1;
                end
            end
            scores_checked <= scores_checked + 1;
        end
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int n;
        foreach (model_counts[i]) model_counts[i] = 0;
        foreach (model_weights[i]) model_weights[i] = 0;
        for (int i = 0; i < N_WEIGHTS; i++)
            queue_load(i, $signed(16'($urandom)) >>> $urandom_range(10, 0));
        // directed: empty position, every code, extreme hands, saturation
        pending_items.push_back(noise_item(bfm_pkg::MODE_EVAL));
        for (int c = -16; c < 16; c++) queue_board(c);
        pending_items.push_back(noise_item(bfm_pkg::MODE_EVAL));
        queue_hand(0, 31, 7, 7, 7, 7, 3, 3);
        queue_hand(1, 31, 7, 7, 7, 7, 3, 3);
        for (int i = 0; i < 8; i++) queue_hand(i & 1, 31, 7, 7, 7, 7, 3, 3);
        pending_items.push_back(noise_item(bfm_pkg::MODE_EVAL));
        queue_load(B2_SLOT, -32768);
        queue_load(W2_BASE, 32767);
        queue_load(0, 32767);
        queue_load(1023, -1);
        queue_hand(0, 31, 0, 0, 0, 0, 0, 0);
        pending_items.push_back(noise_item(bfm_pkg::MODE_EVAL));
        // random positions with some noise
        n = 0;
        while (n < 450) begin
            if ($urandom_range(99) < 85) begin
                for (int k = $urandom_range(20, 5); k > 0; k--) begin
                    queue_board($urandom_range(31) - 16);
                    n++;
                end
                for (int k = $urandom_range(2); k > 0; k--) begin
                    pending_items.push_back(noise_item(bfm_pkg::MODE_HAND));
                    n++;
                end
                pending_items.push_back(noise_item(bfm_pkg::MODE_EVAL));
            end else if ($urandom_range(1)) begin
                pending_items.push_back(noise_item(bfm_pkg::MODE_LOAD));
            end else begin
                pending_items.push_back(noise_item(bfm_pkg::MODE_EVAL));
            end
            n++;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge aclk);
        while (s_valid) @(posedge aclk);
        @(posedge aclk);
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
        $display("run covered %0d accepted items and %0d checked scores, %0d mismatches",
                 items_accepted, scores_checked, mismatches);
        if (mismatches == 0 && expected_scores.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
